[src/piecewise_phase_segmenter_assert.svh]
// Assertion macros shared by the segmenter's modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PIECEWISE_PHASE_SEGMENTER_ASSERT_SVH
`define PIECEWISE_PHASE_SEGMENTER_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define PPSEG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its condition.
`define PPSEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ppseg_pkg.sv]
// Package of the piecewise phase segmenter: fixed widths, register indexes,
// state types, the queue tag and the small set-index function. No dependencies.
package ppseg_pkg;

  localparam int SEG_W      = 3;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int REG_SPLITS = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PSET_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_A     = 3'd2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_LOW,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // Per-item control that travels with the phase through the queue.
  typedef struct packed {
    logic [SEG_W-1:0] segment;
    logic [SEG_W-1:0] param_set;
    logic             param_set_valid;
    logic             reload;
  } ppseg_tag_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } ppseg_q_stat_t;

  // Segment modulo a nonzero set count by repeated subtraction (seg <= 7).
  function automatic logic [SEG_W-1:0] pset_mod(input logic [SEG_W-1:0] seg,
                                                input logic [CNT_W-1:0] cnt);
    logic [SEG_W-1:0] r;
    r = seg;
    for (int i = 0; i < 7; i++) begin
      if (r >= cnt) begin
        r = r - cnt;
      end
    end
    return r;
  endfunction

endpackage

[src/ppseg_front.sv]
// Front end of the segmenter: configuration registers, input acceptance and
// the upward segment search. Depends on ppseg_pkg and the assertion header.
`include "piecewise_phase_segmenter_assert.svh"
module ppseg_front #(
  parameter int MAX_SEGMENTS    = 7,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ppseg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [PHASE_FRAC_BITS:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PHASE_FRAC_BITS:0]          in_phase,
  input  ppseg_pkg::ppseg_q_stat_t          q_stat,
  output logic                              push,
  output ppseg_pkg::ppseg_tag_t             push_tag,
  output logic [PHASE_FRAC_BITS:0]          push_phase,
  output logic [PHASE_FRAC_BITS:0]          push_lo,
  output logic [PHASE_FRAC_BITS:0]          push_hi
);
  import ppseg_pkg::*;

  localparam int PW = PHASE_FRAC_BITS + 1;
  localparam logic [PW-1:0] ONE_PHASE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic [SEG_W-1:0] MAX_SPLITS = SEG_W'(MAX_SEGMENTS - 1);

  front_state_t     state_r, state_nxt;
  logic [PW-1:0]    phase_r, phase_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic [PW-1:0]    hi_cand_r, hi_cand_nxt;
  logic [PW-1:0]    lo_cand_r, lo_cand_nxt;
  logic [PW-1:0]    prev_r, prev_nxt;
  logic [SEG_W-1:0] cur_r, cur_nxt;
  logic             pend_r, pend_nxt;
  logic [PW-1:0]    seg_lo_r, seg_lo_nxt;
  logic [PW-1:0]    seg_hi_r, seg_hi_nxt;

  logic [CNT_W-1:0] split_count_r;
  logic [CNT_W-1:0] pset_count_r;
  logic [PW-1:0]    split_r [REG_SPLITS];

  logic [SEG_W-1:0]     used_n;
  logic [SEG_W-1:0]     rd_addr;
  logic [PW-1:0]        rd_data;
  logic                 step;
  logic                 reload;
  logic [CFG_IDX_W-1:0] split_idx;

  assign used_n    = (split_count_r > MAX_SPLITS) ? MAX_SPLITS : split_count_r;
  assign split_idx = cfg_index - CFG_SPLIT_A;

  // One read port on the split registers: seg-1 while fetching the low bound.
  assign rd_addr = (state_r == F_LOW) ? seg_r - 1'b1 : seg_r;
  assign rd_data = (rd_addr < SEG_W'(REG_SPLITS)) ? split_r[rd_addr] : '0;
  assign step    = (seg_r < used_n) && (phase_r >= rd_data);
  assign reload  = (seg_r != cur_r) || pend_r;

  assign push_tag.segment         = seg_r;
  assign push_tag.param_set       = (pset_count_r != '0) ? pset_mod(seg_r, pset_count_r) : '0;
  assign push_tag.param_set_valid = (pset_count_r != '0);
  assign push_tag.reload          = reload;
  assign push_phase               = phase_r;
  assign push_lo                  = reload ? lo_cand_r : seg_lo_r;
  assign push_hi                  = reload ? hi_cand_r : seg_hi_r;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    seg_nxt     = seg_r;
    hi_cand_nxt = hi_cand_r;
    lo_cand_nxt = lo_cand_r;
    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    pend_nxt    = pend_r;
    seg_lo_nxt  = seg_lo_r;
    seg_hi_nxt  = seg_hi_r;
    in_ready    = 1'b0;
    push        = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          phase_nxt = in_phase;
          seg_nxt   = (in_phase < prev_r) ? '0 : cur_r;
          state_nxt = F_SEARCH;
        end
      end
      F_SEARCH: begin
        if (step) begin
          seg_nxt = seg_r + 1'b1;
        end else begin
          hi_cand_nxt = (seg_r >= used_n) ? ONE_PHASE : rd_data;
          state_nxt   = F_LOW;
        end
      end
      F_LOW: begin
        lo_cand_nxt = (seg_r == '0) ? '0 : rd_data;
        state_nxt   = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          push      = 1'b1;
          prev_nxt  = phase_r;
          cur_nxt   = seg_r;
          pend_nxt  = 1'b0;
          if (reload) begin
            seg_lo_nxt = lo_cand_r;
            seg_hi_nxt = hi_cand_r;
          end
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
    // Any register write forces a bound reload on the next item.
    if (cfg_we) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      prev_r   <= '0;
      cur_r    <= '0;
      pend_r   <= 1'b1;
      seg_lo_r <= '0;
      seg_hi_r <= ONE_PHASE;
    end else begin
      state_r  <= state_nxt;
      prev_r   <= prev_nxt;
      cur_r    <= cur_nxt;
      pend_r   <= pend_nxt;
      seg_lo_r <= seg_lo_nxt;
      seg_hi_r <= seg_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r   <= phase_nxt;
    seg_r     <= seg_nxt;
    hi_cand_r <= hi_cand_nxt;
    lo_cand_r <= lo_cand_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_count_r <= '0;
      pset_count_r  <= '0;
      for (int i = 0; i < REG_SPLITS; i++) begin
        split_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPLIT_COUNT: split_count_r <= cfg_data[CNT_W-1:0];
        CFG_PSET_COUNT:  pset_count_r  <= cfg_data[CNT_W-1:0];
        default:         split_r[split_idx] <= cfg_data;
      endcase
    end
  end

  `PPSEG_ASSERT_NOW(a_push_room, push, !q_stat.full, "front pushed into a full queue")
  `PPSEG_ASSERT_NOW(a_seg_range, state_r == F_SEARCH, seg_r <= MAX_SPLITS,
                    "segment search beyond the last split")
  `PPSEG_ASSERT_NEXT(a_push_clears, push && !cfg_we, !pend_r && cur_r == $past(seg_r),
                     "segment state not committed on push")

endmodule

[src/ppseg_queue.sv]
// Short queue between the segmenter's front and back ends.
// Depends on ppseg_pkg and the assertion header.
`include "piecewise_phase_segmenter_assert.svh"
module ppseg_queue #(
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output ppseg_pkg::ppseg_q_stat_t stat
);
  import ppseg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  assign stat.full  = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `PPSEG_ASSERT_NOW(a_no_underflow, pop, !stat.empty, "pop from an empty queue")

endmodule

[src/ppseg_back.sv]
// Back end of the segmenter: local phase by restoring division, one quotient
// bit per cycle, and the output register. Depends on ppseg_pkg and the header.
`include "piecewise_phase_segmenter_assert.svh"
module ppseg_back #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppseg_pkg::ppseg_q_stat_t      q_stat,
  input  ppseg_pkg::ppseg_tag_t         q_tag,
  input  logic [PHASE_FRAC_BITS:0]      q_phase,
  input  logic [PHASE_FRAC_BITS:0]      q_lo,
  input  logic [PHASE_FRAC_BITS:0]      q_hi,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ppseg_pkg::SEG_W-1:0]   out_segment,
  output logic [ppseg_pkg::SEG_W-1:0]   out_param_set,
  output logic                          out_param_set_valid,
  output logic                          out_reload,
  output logic [PHASE_FRAC_BITS:0]      out_local_phase
);
  import ppseg_pkg::*;

  localparam int PW = PHASE_FRAC_BITS + 1;
  localparam int DC_W = $clog2(PHASE_FRAC_BITS + 1);
  localparam logic [PW-1:0] ONE_PHASE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

  back_state_t               state_r, state_nxt;
  ppseg_tag_t                tag_r, tag_nxt;
  logic [PW-1:0]             rem_r, rem_nxt;
  logic [PW-1:0]             div_r, div_nxt;
  logic [PHASE_FRAC_BITS-1:0] q_r, q_nxt;
  logic [DC_W-1:0]           cnt_r, cnt_nxt;
  logic [PW-1:0]             res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ppseg_tag_t                out_tag_r;
  logic [PW-1:0]             out_local_r;
  logic                      load;
  logic [PW:0]               rem2;
  logic                      qbit;

  assign rem2 = {rem_r, 1'b0};
  assign qbit = (rem2 >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    tag_nxt   = tag_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    pop       = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          tag_nxt = q_tag;
          if (q_hi <= q_lo) begin
            res_nxt   = ONE_PHASE;
            state_nxt = B_DONE;
          end else if (q_phase <= q_lo) begin
            res_nxt   = '0;
            state_nxt = B_DONE;
          end else if (q_phase >= q_hi) begin
            res_nxt   = ONE_PHASE;
            state_nxt = B_DONE;
          end else begin
            rem_nxt   = q_phase - q_lo;
            div_nxt   = q_hi - q_lo;
            q_nxt     = '0;
            cnt_nxt   = DC_W'(PHASE_FRAC_BITS);
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        rem_nxt = qbit ? PW'(rem2 - {1'b0, div_r}) : PW'(rem2);
        q_nxt   = {q_r[PHASE_FRAC_BITS-2:0], qbit};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == DC_W'(1)) begin
          res_nxt   = {1'b0, q_nxt};
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    if (load) begin
      out_tag_r   <= tag_r;
      out_local_r <= res_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_segment         = out_tag_r.segment;
  assign out_param_set       = out_tag_r.param_set;
  assign out_param_set_valid = out_tag_r.param_set_valid;
  assign out_reload          = out_tag_r.reload;
  assign out_local_phase     = out_local_r;

  `PPSEG_ASSERT_NOW(a_rem_below_div, state_r == B_DIV, rem_r < div_r,
                    "division remainder not below divisor")
  `PPSEG_ASSERT_NOW(a_local_clip, out_valid_r, out_local_r <= ONE_PHASE,
                    "local phase above one")

endmodule

[src/piecewise_phase_segmenter.sv]
// Top level of the piecewise phase segmenter: front end, queue, back end.
// Depends on ppseg_pkg, ppseg_front, ppseg_queue and ppseg_back.
//
// Usage:
//   Input channel in_valid/in_ready carries one phase beat (Q1.16 by default,
//   1 << PHASE_FRAC_BITS is 1.0). Result channel out_valid/out_ready carries one
//   beat per input beat: segment, parameter set, set-valid flag, reload flag
//   and local phase within the segment, clipped to [0, 1.0].
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data) taken
//   at any edge with cfg_we high; write it only while the block is idle.
//   Every register write makes the next beat reload its segment bounds.
// Flow:
//   Front end: accept, split search (one split compared per cycle), bound fetch
//   and push, which waits while the queue is full; a new beat is accepted only
//   after the push. Back end: pop, restoring division when the phase lies inside
//   its segment, and load into the output register; the next item is popped only
//   after that load, so the restoring divider sets sustained throughput.
// Reset and stall:
//   Synchronous active-low rst_n clears the configuration registers, segment
//   state and queue; reload is armed for the first beat. When out_ready stays
//   low the result holds, the back end finishes one more item, the queue fills,
//   and then in_ready stays low.
module piecewise_phase_segmenter #(
  parameter int MAX_SEGMENTS    = 7,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ppseg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [PHASE_FRAC_BITS:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PHASE_FRAC_BITS:0]          in_phase,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ppseg_pkg::SEG_W-1:0]       out_segment,
  output logic [ppseg_pkg::SEG_W-1:0]       out_param_set,
  output logic                              out_param_set_valid,
  output logic                              out_reload,
  output logic [PHASE_FRAC_BITS:0]          out_local_phase
);
  import ppseg_pkg::*;

  localparam int PW    = PHASE_FRAC_BITS + 1;
  localparam int TAG_W = $bits(ppseg_tag_t);
  localparam int QW    = TAG_W + 3 * PW;

  ppseg_q_stat_t q_stat;
  logic          push, pop;
  ppseg_tag_t    push_tag, pop_tag;
  logic [PW-1:0] push_phase, push_lo, push_hi;
  logic [PW-1:0] pop_phase, pop_lo, pop_hi;
  logic [QW-1:0] q_wdata, q_rdata;

  // Accept beats, track segment state, search splits, fetch bounds.
  ppseg_front #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_phase   (in_phase),
    .q_stat     (q_stat),
    .push       (push),
    .push_tag   (push_tag),
    .push_phase (push_phase),
    .push_lo    (push_lo),
    .push_hi    (push_hi)
  );

  // Pack classified beats into the queue and unpack at its head.
  assign q_wdata = {push_tag, push_phase, push_lo, push_hi};
  assign {pop_tag, pop_phase, pop_lo, pop_hi} = q_rdata;

  ppseg_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Divide for the local phase and drive the result channel.
  ppseg_back #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_tag               (pop_tag),
    .q_phase             (pop_phase),
    .q_lo                (pop_lo),
    .q_hi                (pop_hi),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_segment         (out_segment),
    .out_param_set       (out_param_set),
    .out_param_set_valid (out_param_set_valid),
    .out_reload          (out_reload),
    .out_local_phase     (out_local_phase)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_phase_segmenter: scoreboard class with a segment
// predictor, plus tasks for the phase channel, the result channel and the config port.
// Depends on ppseg_pkg and the segmenter RTL only.
module tb;
  import ppseg_pkg::*;

  localparam int PFB        = 16;
  localparam int PW         = PFB + 1;
  localparam logic [PW-1:0] PHASE_ONE  = PW'(1) << PFB;
  localparam logic [PW-1:0] PHASE_MAX  = '1;
  localparam int STALL_LIMIT     = 4000;  // cycles with no beat on either channel
  localparam int TAIL_CYCLES     = 40;    // idle cycles run before the final verdict
  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_OFF_CYCLES = 300;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [SEG_W-1:0] segment;
    logic [SEG_W-1:0] param_set;
    logic             param_set_valid;
    logic             reload;
    logic [PW-1:0]    local_phase;
  } segment_beat_t;

  // Tracks config and segment state, predicts each result and checks it on arrival.
  class segmenter_scoreboard;
    logic [2:0]    split_count;
    logic [2:0]    pset_count;
    logic [PW-1:0] splits [REG_SPLITS];
    logic [PW-1:0] prev_phase;
    logic [2:0]    cur_seg;
    logic          reload_armed;
    logic [PW-1:0] seg_lo;
    logic [PW-1:0] seg_hi;
    segment_beat_t expected_beats [$];
    int            error_count;

    function new();
      split_count  = '0;
      pset_count   = '0;
      foreach (splits[i]) splits[i] = '0;
      prev_phase   = '0;
      cur_seg      = '0;
      reload_armed = 1'b1;
      seg_lo       = '0;
      seg_hi       = PHASE_ONE;
      error_count  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PW-1:0] val);
      if (idx == CFG_SPLIT_COUNT) begin
        split_count = val[2:0];
      end else if (idx == CFG_PSET_COUNT) begin
        pset_count = val[2:0];
      end else begin
        splits[idx - CFG_SPLIT_A] = val;
      end
      reload_armed = 1'b1;
    endfunction

    // Search upward (or from zero on retrigger), refresh bounds on reload,
    // then scale the phase into its segment.
    function segment_beat_t predict_segment(logic [PW-1:0] phase);
      segment_beat_t r;
      int unsigned   n;
      int unsigned   seg;
      logic          reload;
      logic [33:0]   num;
      logic [33:0]   quo;
      n   = (split_count > REG_SPLITS) ? REG_SPLITS : split_count;
      seg = (phase < prev_phase) ? 0 : cur_seg;
      while (seg < n && phase >= splits[seg]) seg++;
      reload = (seg != cur_seg) || reload_armed;
      if (reload) begin
        seg_lo = (seg == 0) ? '0 : splits[seg-1];
        seg_hi = (seg >= n) ? PHASE_ONE : splits[seg];
      end
      prev_phase   = phase;
      cur_seg      = 3'(seg);
      reload_armed = 1'b0;
      if (seg_hi <= seg_lo) begin
        r.local_phase = PHASE_ONE;
      end else if (phase <= seg_lo) begin
        r.local_phase = '0;
      end else if (phase >= seg_hi) begin
        r.local_phase = PHASE_ONE;
      end else begin
        num = 34'(phase - seg_lo) << PFB;
        quo = num / 34'(seg_hi - seg_lo);
        r.local_phase = (quo > 34'(PHASE_ONE)) ? PHASE_ONE : PW'(quo);
      end
      r.segment         = 3'(seg);
      r.param_set       = (pset_count != 0) ? 3'(seg % pset_count) : '0;
      r.param_set_valid = (pset_count != 0);
      r.reload          = reload;
      return r;
    endfunction

    function void note_phase(logic [PW-1:0] phase);
      expected_beats.push_back(predict_segment(phase));
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        error_count++;
      end
    endfunction

    function void check_beat(segment_beat_t got);
      segment_beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual %p",
                 $time, got);
        error_count++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("segment", want.segment, got.segment);
      compare_field("param_set", want.param_set, got.param_set);
      compare_field("param_set_valid", want.param_set_valid, got.param_set_valid);
      compare_field("reload", want.reload, got.reload);
      compare_field("local_phase", want.local_phase, got.local_phase);
    endfunction

    function int pending_count();
      return expected_beats.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PW-1:0]        cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [PW-1:0]        in_phase;
  logic                 out_valid;
  logic                 out_ready;
  logic [SEG_W-1:0]     out_segment;
  logic [SEG_W-1:0]     out_param_set;
  logic                 out_param_set_valid;
  logic                 out_reload;
  logic [PW-1:0]        out_local_phase;

  segmenter_scoreboard sb;
  logic [PW-1:0] cur_splits [REG_SPLITS];  // split values last loaded, used to aim phases
  int idle_pct;       // percent of cycles the phase sender sits idle
  int stall_pct;      // percent of cycles the result side deasserts ready
  int hold_cycles;    // pending long hold-off of out_ready, consumed by the receiver
  int sent_count;
  int idle_cycles;

  piecewise_phase_segmenter #(
    .MAX_SEGMENTS   (7),
    .PHASE_FRAC_BITS(PFB)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_phase           (in_phase),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_segment        (out_segment),
    .out_param_set      (out_param_set),
    .out_param_set_valid(out_param_set_valid),
    .out_reload         (out_reload),
    .out_local_phase    (out_local_phase)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: drop ready at random, or hold it low for a counted stretch on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor both channels at the rising edge; any beat resets the stall counter.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && in_valid && in_ready) sb.note_phase(in_phase);
      if (rst_n && out_valid && out_ready) begin
        sb.check_beat('{out_segment, out_param_set, out_param_set_valid,
                        out_reload, out_local_phase});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Watchdog: give up once neither channel has moved for too long.
  initial begin
    @(posedge clk);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one phase beat after a random idle gap; hold it until accepted.
  task automatic send_phase(input logic [PW-1:0] phase);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_phase = phase;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Write every register; count writes carry junk in the upper bits, which must be dropped.
  task automatic load_setup(input logic [2:0] split_cnt, input logic [2:0] pset_cnt);
    logic [PW-1:0] junk;
    junk = PW'($urandom);
    write_reg(CFG_SPLIT_COUNT, {junk[PW-1:3], split_cnt});
    junk = PW'($urandom);
    write_reg(CFG_PSET_COUNT, {junk[PW-1:3], pset_cnt});
    for (int i = 0; i < REG_SPLITS; i++) write_reg(CFG_IDX_W'(CFG_SPLIT_A + i), cur_splits[i]);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Draw split points: ascending within [0, 1.0] most of the time, else raw 17-bit values.
  task automatic draw_splits(input bit sorted);
    int vals [$];
    vals = {};
    for (int i = 0; i < REG_SPLITS; i++) begin
      vals.push_back(sorted ? $urandom_range(0, 65536) : $urandom_range(0, 131071));
    end
    if (sorted) vals.sort();
    for (int i = 0; i < REG_SPLITS; i++) cur_splits[i] = PW'(vals[i]);
  endtask

  // One gesture: mostly a rising sweep, sometimes landing on a split point;
  // otherwise a short burst of random phases.
  task automatic play_gesture();
    int          len;
    int unsigned pos;
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(1, 6);
      repeat (len) send_phase(PW'($urandom_range(0, 131071)));
    end else begin
      len = $urandom_range(3, 24);
      pos = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 20000);
      repeat (len) begin
        if ($urandom_range(9) == 0) begin
          send_phase(cur_splits[$urandom_range(0, REG_SPLITS - 1)]);
        end else begin
          send_phase(PW'(pos));
        end
        pos += $urandom_range(0, 140000 / len);
        if (pos > PHASE_MAX) pos = PHASE_MAX;
      end
    end
  endtask

  initial begin
    logic [2:0] split_cnt;
    logic [2:0] pset_cnt;
    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_phase    = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    sent_count  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: three evenly spaced splits; hit each split exactly, run past 1.0,
    // then retrigger and repeat a phase.
    cur_splits = '{17'd16384, 17'd32768, 17'd49152, PHASE_ONE, 17'd0, PHASE_MAX};
    load_setup(3'd3, 3'd2);
    foreach (cur_splits[i]) ;
    send_phase(17'd0);
    send_phase(17'd8192);
    send_phase(17'd16384);
    send_phase(17'd20000);
    send_phase(17'd32768);
    send_phase(17'd49151);
    send_phase(17'd49152);
    send_phase(PHASE_ONE);
    send_phase(17'd70000);
    send_phase(PHASE_MAX);
    send_phase(17'd100);
    send_phase(17'd100);
    end_stream();
    wait_drained();

    // Directed: split count beyond six saturates; duplicate splits make an empty
    // segment, a falling split makes a reversed one.
    cur_splits = '{17'd10000, 17'd10000, 17'd5000, 17'd60000, PHASE_ONE, PHASE_MAX};
    load_setup(3'd7, 3'd7);
    send_phase(17'd0);
    send_phase(17'd9999);
    send_phase(17'd10000);
    send_phase(17'd65535);
    send_phase(PHASE_ONE);
    send_phase(17'd131070);
    send_phase(PHASE_MAX);
    end_stream();
    wait_drained();

    // Directed: drop the split count under the current segment; it must be kept,
    // with lo read from the split below it. No parameter sets loaded.
    load_setup(3'd1, 3'd0);
    send_phase(PHASE_MAX);
    send_phase(PHASE_ONE);
    send_phase(17'd0);
    end_stream();
    wait_drained();

    // Random phases: new setup each time, idling pattern rotates.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          draw_splits(1'b1);
          split_cnt = 3'd0;
          pset_cnt  = 3'd0;
        end
        1: begin
          draw_splits(1'b1);
          cur_splits[REG_SPLITS-1] = PHASE_ONE;
          split_cnt = 3'd6;
          pset_cnt  = 3'd7;
        end
        2: begin
          draw_splits(1'b1);
          cur_splits[2] = cur_splits[1];
          split_cnt = 3'd7;
          pset_cnt  = 3'd1;
        end
        3: begin
          draw_splits(1'b0);
          split_cnt = 3'd6;
          pset_cnt  = 3'd6;
        end
        default: begin
          draw_splits($urandom_range(99) < 85);
          split_cnt = 3'($urandom_range(0, 7));
          pset_cnt  = 3'($urandom_range(0, 7));
        end
      endcase
      load_setup(split_cnt, pset_cnt);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      // Hold the result side off while phases keep coming, so the queue fills
      // and in_ready has to drop.
      if (p == PRESSURE_PHASE) hold_cycles = HOLD_OFF_CYCLES;
      sent_count = 0;
      while (sent_count < ITEMS_PER_PHASE) play_gesture();
      end_stream();
      wait_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/ppseg_pkg.sv
src/ppseg_front.sv
src/ppseg_queue.sv
src/ppseg_back.sv
src/piecewise_phase_segmenter.sv
tb/sv/tb.sv
